>>> rtl/core/kvt_pkg.sv
// Shared constants, operation and status codes, and the cell control bundle.
`default_nettype none
package kvt_pkg;

  localparam int KEY_W         = 32;
  localparam int COUNT_W       = 6;
  localparam int DEF_DEPTH     = 32;
  localparam int DEF_VALUE_W   = 64;

  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_GET   = 3'd1;
  localparam logic [2:0] OP_DEL   = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_LIST  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_BAD_KEY = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Commands broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic compare;
    logic update;
    logic append;
    logic remove;
    logic rotate;
  } kvt_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/kvt_cell.sv
// One table cell: holds a key and value, compares, shifts and rotates with its neighbors.
`default_nettype none
module kvt_cell
  import kvt_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = DEF_VALUE_W,
  parameter int CW          = 6
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire  kvt_ctrl_t        ctrl,
  input  wire  [CW-1:0]          used,
  input  wire  [KEY_W-1:0]       req_key,
  input  wire  [VALUE_WIDTH-1:0] req_value,
  input  wire  [KEY_W-1:0]       next_key,
  input  wire  [VALUE_WIDTH-1:0] next_value,
  input  wire  [KEY_W-1:0]       head_key,
  input  wire  [VALUE_WIDTH-1:0] head_value,
  input  wire                    shift_in,
  output logic                   shift_out,
  input  wire  [VALUE_WIDTH-1:0] sum_in,
  output logic [VALUE_WIDTH-1:0] sum_out,
  output logic                   hit,
  output logic [KEY_W-1:0]       key_q,
  output logic [VALUE_WIDTH-1:0] value_q
);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

  logic occupied;

  assign occupied  = MY_IDX < used;
  // Every cell at or after the matching one moves down on a delete.
  assign shift_out = shift_in | hit;
  assign sum_out   = sum_in | (hit ? value_q : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.compare) begin
      hit <= occupied && (key_q == req_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update && hit) begin
      value_q <= req_value;
    end
    if (ctrl.append && (MY_IDX == used)) begin
      key_q   <= req_key;
      value_q <= req_value;
    end
    if (ctrl.remove && shift_out) begin
      key_q   <= next_key;
      value_q <= next_value;
    end
    // During a listing the occupied cells form a ring closed at the last one.
    if (ctrl.rotate) begin
      if (NEXT_IDX == used) begin
        key_q   <= head_key;
        value_q <= head_value;
      end else if (NEXT_IDX < used) begin
        key_q   <= next_key;
        value_q <= next_value;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/key_value_table.sv
// Top level of the key-value table: command controller and the row of cells.
//
//   channel   direction  handshake                      payload
//   command   in         start, busy (taken: start&!busy) operation, key, value
//   result    out        strobe (one cycle, no stall)    status, key_out, value_out,
//                                                          entry_count, last
//
// Put, get, delete and clear: keys are compared in every cell at the edge that
// takes the item, and the action plus the result register follow in the next
// cycle. List then shows one result per entry while the cells rotate past the
// head cell one entry per cycle.
// Reset empties the table at once; no clearing pass is needed.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none
module key_value_table
  import kvt_pkg::*;
#(
  parameter int DEPTH       = DEF_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_W
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire  [2:0]                 operation,
  input  wire  signed [KEY_W-1:0]    key,
  input  wire  [VALUE_WIDTH-1:0]     value,
  output logic                       strobe,
  output logic [1:0]                 status,
  output logic signed [KEY_W-1:0]    key_out,
  output logic [VALUE_WIDTH-1:0]     value_out,
  output logic [COUNT_W-1:0]         entry_count,
  output logic                       last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_ACT, S_LIST} state_t;

  state_t                 state;
  logic [2:0]             op_r;
  logic [KEY_W-1:0]       key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [CW-1:0]          used;
  logic [CW-1:0]          used_next;
  logic [CW-1:0]          lcnt;

  kvt_ctrl_t              ctrl;
  logic [KEY_W-1:0]       cell_key   [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic [DEPTH:0]         shift_chain;
  logic [VALUE_WIDTH-1:0] sum_chain  [DEPTH+1];
  logic [DEPTH-1:0]       hits;

  logic valid_key;
  logic any_hit;
  logic full;
  logic list_last;

  assign busy      = (state != S_IDLE);
  assign valid_key = (key_r != '0);
  assign any_hit   = shift_chain[DEPTH];
  assign full      = (used == FULL_COUNT);
  assign list_last = (lcnt == used - CW'(1));

  assign shift_chain[0] = 1'b0;
  assign sum_chain[0]   = '0;

  always_comb begin
    ctrl.compare = start && !busy;
    ctrl.update  = (state == S_ACT) && (op_r == OP_PUT) && valid_key;
    ctrl.append  = (state == S_ACT) && (op_r == OP_PUT) && valid_key && !any_hit && !full;
    ctrl.remove  = (state == S_ACT) && (op_r == OP_DEL) && valid_key && any_hit;
    ctrl.rotate  = (state == S_LIST);
  end

  always_comb begin
    used_next = used;
    if (ctrl.append) begin
      used_next = used + CW'(1);
    end else if (ctrl.remove) begin
      used_next = used - CW'(1);
    end else if ((state == S_ACT) && (op_r == OP_CLEAR)) begin
      used_next = '0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]       nk;
    logic [VALUE_WIDTH-1:0] nv;
    if (i == DEPTH - 1) begin : g_end
      assign nk = cell_key[i];
      assign nv = cell_value[i];
    end else begin : g_mid
      assign nk = cell_key[i+1];
      assign nv = cell_value[i+1];
    end

    kvt_cell #(
      .IDX         (i),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CW          (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .used       (used),
      .req_key    (ctrl.compare ? key : key_r),
      .req_value  (value_r),
      .next_key   (nk),
      .next_value (nv),
      .head_key   (cell_key[0]),
      .head_value (cell_value[0]),
      .shift_in   (shift_chain[i]),
      .shift_out  (shift_chain[i+1]),
      .sum_in     (sum_chain[i]),
      .sum_out    (sum_chain[i+1]),
      .hit        (hits[i]),
      .key_q      (cell_key[i]),
      .value_q    (cell_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      lcnt   <= '0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      used   <= used_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= operation;
            key_r   <= key;
            value_r <= value;
            state   <= S_ACT;
          end
        end
        S_ACT: begin
          state       <= S_IDLE;
          key_out     <= key_r;
          value_out   <= '0;
          entry_count <= COUNT_W'(used_next);
          last        <= 1'b1;
          case (op_r)
            OP_PUT: begin
              strobe <= 1'b1;
              if (!valid_key) begin
                status <= ST_BAD_KEY;
              end else if (!any_hit && full) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
              end
            end
            OP_GET, OP_DEL: begin
              strobe <= 1'b1;
              if (!valid_key) begin
                status <= ST_BAD_KEY;
              end else if (!any_hit) begin
                status <= ST_MISSING;
              end else begin
                status <= ST_OK;
                if (op_r == OP_GET) begin
                  value_out <= sum_chain[DEPTH];
                end
              end
            end
            OP_CLEAR: begin
              strobe  <= 1'b1;
              status  <= ST_OK;
              key_out <= '0;
            end
            OP_LIST: begin
              key_out <= '0;
              if (used == '0) begin
                strobe <= 1'b1;
                status <= ST_MISSING;
              end else begin
                lcnt  <= '0;
                state <= S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
        S_LIST: begin
          strobe      <= 1'b1;
          status      <= ST_OK;
          key_out     <= cell_key[0];
          value_out   <= cell_value[0];
          entry_count <= COUNT_W'(used);
          last        <= list_last;
          lcnt        <= lcnt + CW'(1);
          if (list_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Keys are unique in the table, so at most one cell can match.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hits))
    else $error("more than one cell matched the key");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= FULL_COUNT)
    else $error("entry count exceeds table depth");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.remove |=> (used == $past(used) - CW'(1)))
    else $error("delete did not lower the entry count by one");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final result shown while still busy");

  a_list_stream: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |=> strobe)
    else $error("listing skipped a cycle");
`endif

endmodule
`default_nettype wire
